/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define AMF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked always, reset included
`define AMF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/amf_pkg.sv */
// Shared types, codes and defaults of the adaptive median filter.
// No dependencies.
`timescale 1ns / 1ps

package amf_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DEF_MAX_WINDOW = 11;

    localparam int PIX_W      = 8;
    localparam int WIN_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int CNT_W      = 8;
    localparam int NUM_LANES  = 15;
    localparam int Q_DEPTH    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_MIN_WINDOW   = 3'd2,
        CFG_MAX_WINDOW   = 3'd3,
        CFG_FILTER_MODE  = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_opcode;

    typedef enum logic {
        MODE_ADAPTIVE = 1'b0,
        MODE_PLAIN    = 1'b1
    } t_mode;

    localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 10'd512;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 10'd512;
    localparam logic [WIN_W-1:0]      RST_MIN_WINDOW   = 4'd3;
    localparam logic [WIN_W-1:0]      RST_MAX_WINDOW   = 4'd11;

    typedef struct packed {
        logic [WIN_W-1:0] lo;
        logic [WIN_W-1:0] hi;
        t_mode            mode;
    } t_win_cfg;

    function automatic logic [WIN_W-1:0] odd_clamp(input logic [WIN_W-1:0] v,
                                                   input logic [WIN_W-1:0] top);
        logic [WIN_W-1:0] o;
        o = v | 4'd1;
        if (o < 4'd3) o = 4'd3;
        if (o > top) o = top;
        return o;
    endfunction

endpackage

/* hw/rtl/amf_in_if.sv */
// Input channel: valid/ready handshake carrying one pixel or flush word.
// Depends on amf_pkg.
`timescale 1ns / 1ps

interface amf_in_if;
    import amf_pkg::*;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [PIX_W-1:0]   pixel_in;

    modport source (output valid, output opcode, output pixel_in, input ready);
    modport sink   (input valid, input opcode, input pixel_in, output ready);
endinterface

/* hw/rtl/amf_out_if.sv */
// Output channel: valid/ready handshake carrying one filtered pixel word.
// Depends on amf_pkg.
`timescale 1ns / 1ps

interface amf_out_if;
    import amf_pkg::*;
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   filtered_pixel;
    logic [WIN_W-1:0]   window_used;
    logic               kept_center;
    logic               frame_end;

    modport source (output valid, output filtered_pixel, output window_used,
                    output kept_center, output frame_end, input ready);
    modport sink   (input valid, input filtered_pixel, input window_used,
                    input kept_center, input frame_end, output ready);
endinterface

/* hw/rtl/amf_fifo.sv */
// Small job queue between the front and back ends.
// Depends on amf_pkg for the default depth.
`timescale 1ns / 1ps

module amf_fifo #(
    parameter int DW    = 8,
    parameter int DEPTH = amf_pkg::Q_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_empty,
    output logic          o_full
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= nxt(r_wp);
            if (i_pop)  r_rp <= nxt(r_rp);
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule

/* hw/rtl/amf_front.sv */
// Front end: accepts input words, writes the line store, tracks raster
// positions and issues one output job per due pixel. Depends on amf_pkg, amf_in_if.
`timescale 1ns / 1ps

module amf_front #(
    parameter int MAX_WIDTH  = amf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = amf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = amf_pkg::DEF_MAX_WINDOW,
    localparam int WW   = $clog2(MAX_WIDTH),
    localparam int RW   = $clog2(MAX_HEIGHT),
    localparam int WDW  = $clog2(MAX_WIDTH + 1),
    localparam int HW   = $clog2(MAX_HEIGHT + 1),
    localparam int TOPW = ((MAX_WINDOW - 1) | 1),
    localparam int LR   = $clog2(3 * (TOPW / 2) + 8),
    localparam int AW   = LR + WW,
    localparam int JW   = RW + WW + 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    amf_in_if.sink                          i_pix,
    input  logic [WDW-1:0]                  i_width,
    input  logic [HW-1:0]                   i_height,
    input  logic [amf_pkg::WIN_W-1:0]       i_hi_win,
    input  logic                            i_q_full,
    input  logic                            i_back_quiet,
    output logic                            o_wr_en,
    output logic [AW-1:0]                   o_wr_addr,
    output logic [amf_pkg::PIX_W-1:0]       o_wr_data,
    output logic                            o_push,
    output logic [JW-1:0]                   o_job
);
    import amf_pkg::*;

    localparam int CNTW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    logic [RW-1:0]   r_in_row, r_out_row;
    logic [WW-1:0]   r_in_col, r_out_col;
    logic [CNTW-1:0] r_cnt_in, r_cnt_out, r_lag;
    logic            r_done, r_drain;

    logic            v_acc, v_is_pix, v_in_eol, v_in_eof, v_n_done, v_out_eol, v_last;
    logic [CNTW-1:0] v_n_cnt_in;
    logic [2:0]      v_rad;

    assign i_pix.ready = !r_drain && !i_q_full;
    assign v_acc       = i_pix.valid && i_pix.ready;
    assign v_is_pix    = (i_pix.opcode == OP_PIXEL) && !r_done;
    assign v_rad       = 3'(i_hi_win >> 1);

    always_comb begin
        v_in_eol   = (WDW + 1)'(r_in_col) + 1'b1 >= (WDW + 1)'(i_width);
        v_in_eof   = v_in_eol && ((HW + 1)'(r_in_row) + 1'b1 >= (HW + 1)'(i_height));
        v_n_done   = r_done || (v_is_pix && v_in_eof);
        v_n_cnt_in = v_is_pix ? r_cnt_in + 1'b1 : r_cnt_in;
        v_out_eol  = (WDW + 1)'(r_out_col) + 1'b1 >= (WDW + 1)'(i_width);
        v_last     = v_out_eol && ((HW + 1)'(r_out_row) + 1'b1 >= (HW + 1)'(i_height));
        o_push     = v_acc && (v_is_pix || r_done) &&
                     (v_n_done || ((CNTW + 1)'(v_n_cnt_in) >=
                      (CNTW + 1)'(r_cnt_out) + (CNTW + 1)'(r_lag) + 1'b1));
    end

    assign o_wr_en   = v_acc && v_is_pix;
    assign o_wr_addr = {LR'(r_in_row), r_in_col};
    assign o_wr_data = i_pix.pixel_in;
    assign o_job     = {r_out_row, r_out_col, v_last};

    always_ff @(posedge i_clk) begin
        r_lag <= CNTW'(v_rad) * CNTW'(i_width) + CNTW'(v_rad);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_cnt_in  <= '0;
            r_cnt_out <= '0;
            r_done    <= 1'b0;
            r_drain   <= 1'b0;
        end else begin
            if (r_drain && i_back_quiet) r_drain <= 1'b0;
            if (v_acc && v_is_pix) begin
                r_cnt_in <= v_n_cnt_in;
                if (v_in_eol) begin
                    r_in_col <= '0;
                    if (v_in_eof) begin
                        r_in_row <= '0;
                        r_done   <= 1'b1;
                    end else begin
                        r_in_row <= r_in_row + 1'b1;
                    end
                end else begin
                    r_in_col <= r_in_col + 1'b1;
                end
            end
            if (o_push) begin
                r_cnt_out <= r_cnt_out + 1'b1;
                if (v_last) begin
                    r_in_row  <= '0;
                    r_in_col  <= '0;
                    r_out_row <= '0;
                    r_out_col <= '0;
                    r_cnt_in  <= '0;
                    r_cnt_out <= '0;
                    r_done    <= 1'b0;
                    r_drain   <= 1'b1;
                end else if (v_out_eol) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + 1'b1;
                end else begin
                    r_out_col <= r_out_col + 1'b1;
                end
            end
        end
    end
endmodule

/* hw/rtl/amf_back.sv */
// Back end: owns the line store, walks each window through it and ranks
// pixels with 15 threshold counters, two passes per window. Depends on amf_pkg, amf_out_if.
`timescale 1ns / 1ps

module amf_back #(
    parameter int MAX_WIDTH  = amf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = amf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = amf_pkg::DEF_MAX_WINDOW,
    localparam int WW   = $clog2(MAX_WIDTH),
    localparam int RW   = $clog2(MAX_HEIGHT),
    localparam int WDW  = $clog2(MAX_WIDTH + 1),
    localparam int HW   = $clog2(MAX_HEIGHT + 1),
    localparam int TOPW = ((MAX_WINDOW - 1) | 1),
    localparam int LR   = $clog2(3 * (TOPW / 2) + 8),
    localparam int AW   = LR + WW,
    localparam int JW   = RW + WW + 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [amf_pkg::PIX_W-1:0]   i_wr_data,
    input  logic                        i_q_empty,
    input  logic [JW-1:0]               i_job,
    output logic                        o_pop,
    input  logic [WDW-1:0]              i_width,
    input  logic [HW-1:0]               i_height,
    input  amf_pkg::t_win_cfg           i_win,
    output logic                        o_idle,
    amf_out_if.source                   o_pix
);
    import amf_pkg::*;

    localparam int SR = RW + 2;
    localparam int SC = WW + 2;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CTR   = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_PASS  = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_EVAL  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    logic [PIX_W-1:0] r_mem [2**AW];
    logic [PIX_W-1:0] r_rdata;

    t_state            r_state;
    logic [RW-1:0]     r_row;
    logic [WW-1:0]     r_col;
    logic              r_last;
    logic signed [4:0] r_dy, r_dx;
    logic [WIN_W-1:0]  r_s;
    logic              r_pass, r_rd_vld;
    logic [3:0]        r_hn;
    logic [PIX_W-1:0]  r_center, r_zmin, r_zmax;
    logic [CNT_W-1:0]  r_cnt [NUM_LANES];
    logic [PIX_W-1:0]  r_res_pix;
    logic [WIN_W-1:0]  r_res_win;
    logic              r_res_kept;
    logic              r_out_vld;
    logic [PIX_W-1:0]  r_out_pix;
    logic [WIN_W-1:0]  r_out_win;
    logic              r_out_kept, r_out_end;

    logic signed [SR-1:0] v_rr;
    logic signed [SC-1:0] v_cc;
    logic [RW-1:0]        v_row;
    logic [WW-1:0]        v_col;
    logic [AW-1:0]        v_rd_addr;
    logic signed [4:0]    v_half, v_nhalf;
    logic [CNT_W-1:0]     v_rank;
    logic [3:0]           v_nib;
    logic [PIX_W-1:0]     v_med;
    logic [WIN_W-1:0]     v_s2;
    logic                 v_out_free;

    assign v_half  = 5'(r_s >> 1);
    assign v_s2    = r_s + 4'd2;
    assign v_nhalf = -(5'(v_s2 >> 1));
    assign v_rank  = (CNT_W'(r_s) * CNT_W'(r_s)) >> 1;

    always_comb begin
        v_rr = $signed(SR'(r_row)) + SR'(r_dy);
        v_cc = $signed(SC'(r_col)) + SC'(r_dx);
        if (v_rr < 0)                          v_row = '0;
        else if (v_rr >= $signed(SR'(i_height))) v_row = RW'(i_height - 1'b1);
        else                                   v_row = RW'(v_rr);
        if (v_cc < 0)                          v_col = '0;
        else if (v_cc >= $signed(SC'(i_width)))  v_col = WW'(i_width - 1'b1);
        else                                   v_col = WW'(v_cc);
        v_rd_addr = {LR'(v_row), v_col};
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        r_rdata <= r_mem[v_rd_addr];
    end

    always_comb begin
        v_nib = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            v_nib = v_nib + 4'(r_cnt[k] <= v_rank);
        end
        v_med = {r_hn, v_nib};
    end

    // rank lanes: lane k counts pixels below its threshold
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD || (r_state == S_EVAL)) begin
            for (int k = 0; k < NUM_LANES; k++) r_cnt[k] <= '0;
        end else if (r_rd_vld) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                if (r_rdata < (r_pass ? {r_hn, 4'(k + 1)} : {4'(k + 1), 4'd0}))
                    r_cnt[k] <= r_cnt[k] + 1'b1;
            end
        end
    end

    assign v_out_free = !r_out_vld || o_pix.ready;
    assign o_pop      = (r_state == S_IDLE) && !i_q_empty;
    assign o_idle     = (r_state == S_IDLE);

    assign o_pix.valid          = r_out_vld;
    assign o_pix.filtered_pixel = r_out_pix;
    assign o_pix.window_used    = r_out_win;
    assign o_pix.kept_center    = r_out_kept;
    assign o_pix.frame_end      = r_out_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_PASS);
            if (r_out_vld && o_pix.ready) r_out_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        {r_row, r_col, r_last} <= i_job;
                        r_dy    <= '0;
                        r_dx    <= '0;
                        r_s     <= i_win.lo;
                        r_state <= S_CTR;
                    end
                end
                S_CTR: r_state <= S_LOAD;
                S_LOAD: begin
                    r_center <= r_rdata;
                    r_dy     <= -v_half;
                    r_dx     <= -v_half;
                    r_pass   <= 1'b0;
                    r_zmin   <= '1;
                    r_zmax   <= '0;
                    r_state  <= S_PASS;
                end
                S_PASS: begin
                    if (r_dx == v_half) begin
                        r_dx <= -v_half;
                        if (r_dy == v_half) r_state <= S_DRAIN;
                        else                r_dy    <= r_dy + 1'b1;
                    end else begin
                        r_dx <= r_dx + 1'b1;
                    end
                end
                S_DRAIN: r_state <= S_EVAL;
                S_EVAL: begin
                    r_res_kept <= 1'b0;
                    r_res_pix  <= v_med;
                    r_res_win  <= r_s;
                    if (!r_pass) begin
                        r_hn    <= v_nib;
                        r_pass  <= 1'b1;
                        r_dy    <= -v_half;
                        r_dx    <= -v_half;
                        r_state <= S_PASS;
                    end else if (i_win.mode == MODE_PLAIN) begin
                        r_state <= S_OUT;
                    end else if (r_zmin < v_med && v_med < r_zmax) begin
                        if (r_zmin < r_center && r_center < r_zmax) begin
                            r_res_pix  <= r_center;
                            r_res_kept <= 1'b1;
                        end
                        r_state <= S_OUT;
                    end else if (r_s >= i_win.hi) begin
                        r_state <= S_OUT;
                    end else begin
                        r_s     <= v_s2;
                        r_pass  <= 1'b0;
                        r_zmin  <= '1;
                        r_zmax  <= '0;
                        r_dy    <= v_nhalf;
                        r_dx    <= v_nhalf;
                        r_state <= S_PASS;
                    end
                end
                S_OUT: begin
                    if (v_out_free) begin
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_rd_vld && !r_pass) begin
                if (r_rdata < r_zmin) r_zmin <= r_rdata;
                if (r_rdata > r_zmax) r_zmax <= r_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && v_out_free) begin
            r_out_pix  <= r_res_pix;
            r_out_win  <= r_res_win;
            r_out_kept <= r_res_kept;
            r_out_end  <= r_last;
        end
    end
endmodule

/* hw/rtl/adaptive_median_filter_top.sv */
// Top level of the adaptive median filter: config registers, front end,
// job queue and back end. Depends on amf_pkg, amf_in_if, amf_out_if and the amf_* modules.
`timescale 1ns / 1ps
// Usage:
//  i_pix takes one word per handshake (valid and ready high): a pixel in
//  raster order or a flush word. After the last pixel of a frame, send
//  flush words until the word with frame_end has left; each flush word
//  releases one filtered pixel.
//  o_pix gives filtered pixels in raster order, R rows plus R pixels
//  behind the input, R being half the effective largest window.
//  Config writes (i_cfg_wr_en, i_cfg_addr, i_cfg_wr_data) are taken at
//  once and must be made while the block is idle.
//  Per output pixel the back end reads every pixel of each window it tries
//  from the line store twice, one read per cycle, between its setup and
//  its handoff. Plain mode tries only the smallest window; an adaptive
//  pixel can try windows of side 3 to 11.
//  A two-word job queue lets input continue while the back end works; the
//  input stalls when it is full and after a frame's last job until the back
//  end has drained. A stalled receiver holds the output word and backs up
//  into the queue. Synchronous reset clears all control state; the line
//  store keeps its contents.

module adaptive_median_filter_top #(
    parameter int MAX_WIDTH  = amf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = amf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = amf_pkg::DEF_MAX_WINDOW
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [amf_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [amf_pkg::CFG_DATA_W-1:0]  i_cfg_wr_data,
    amf_in_if.sink                          i_pix,
    amf_out_if.source                       o_pix
);
    import amf_pkg::*;

    localparam int WW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WDW  = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int TOPW = ((MAX_WINDOW - 1) | 1);
    localparam int LR   = $clog2(3 * (TOPW / 2) + 8);
    localparam int AW   = LR + WW;
    localparam int JW   = RW + WW + 1;

    logic [CFG_DATA_W-1:0] r_frame_width, r_frame_height;
    logic [WIN_W-1:0]      r_min_window, r_max_window;
    logic                  r_filter_mode;

    logic [WDW-1:0]   v_width;
    logic [HW-1:0]    v_height;
    t_win_cfg         v_win;
    logic [WIN_W-1:0] v_lo, v_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_min_window   <= RST_MIN_WINDOW;
            r_max_window   <= RST_MAX_WINDOW;
            r_filter_mode  <= MODE_ADAPTIVE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wr_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wr_data;
                CFG_MIN_WINDOW:   r_min_window   <= i_cfg_wr_data[WIN_W-1:0];
                CFG_MAX_WINDOW:   r_max_window   <= i_cfg_wr_data[WIN_W-1:0];
                CFG_FILTER_MODE:  r_filter_mode  <= i_cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_frame_width == '0)                   v_width = WDW'(1);
        else if (32'(r_frame_width) > MAX_WIDTH)   v_width = WDW'(MAX_WIDTH);
        else                                       v_width = WDW'(r_frame_width);
        if (r_frame_height == '0)                  v_height = HW'(1);
        else if (32'(r_frame_height) > MAX_HEIGHT) v_height = HW'(MAX_HEIGHT);
        else                                       v_height = HW'(r_frame_height);
        v_lo = odd_clamp(r_min_window, WIN_W'(TOPW));
        v_hi = odd_clamp(r_max_window, WIN_W'(TOPW));
        if (v_hi < v_lo) v_hi = v_lo;
        v_win.lo   = v_lo;
        v_win.hi   = v_hi;
        v_win.mode = t_mode'(r_filter_mode);
    end

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [PIX_W-1:0]    wr_data;
    logic                q_push, q_pop, q_empty, q_full, back_idle;
    logic [JW-1:0]       q_in, q_out;

    amf_front #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_WINDOW(MAX_WINDOW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (i_pix),
        .i_width      (v_width),
        .i_height     (v_height),
        .i_hi_win     (v_hi),
        .i_q_full     (q_full),
        .i_back_quiet (back_idle && q_empty),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_push       (q_push),
        .o_job        (q_in)
    );

    amf_fifo #(.DW(JW), .DEPTH(Q_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    amf_back #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_WINDOW(MAX_WINDOW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_q_empty (q_empty),
        .i_job     (q_out),
        .o_pop     (q_pop),
        .i_width   (v_width),
        .i_height  (v_height),
        .i_win     (v_win),
        .o_idle    (back_idle),
        .o_pix     (o_pix)
    );
endmodule

/* hw/rtl/amf_checker.sv */
// Port-level checks of the adaptive median filter, bound to the top level.
// Depends on assert_macros.svh and amf_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module amf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [13:0] i_out_word
);
    logic [31:0] r_bal;
    logic        v_in_hs, v_out_hs;

    assign v_in_hs  = i_in_valid && i_in_ready;
    assign v_out_hs = i_out_valid && i_out_ready;

    // accepted input words not yet matched by an output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bal <= '0;
        end else begin
            r_bal <= r_bal + 32'(v_in_hs) - 32'(v_out_hs);
        end
    end

    `AMF_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word), "output word changed while stalled")
    `AMF_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !i_out_valid, "output valid right after reset")
    `AMF_ASSERT(a_no_invent, v_out_hs |-> r_bal != '0, "output word without a pending input word")
    `AMF_ASSERT(a_win_odd, i_out_valid |-> i_out_word[2], "even window size reported")
endmodule

bind adaptive_median_filter_top amf_checker u_amf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_word  ({o_pix.filtered_pixel, o_pix.window_used, o_pix.kept_center,
                   o_pix.frame_end})
);
